>>> rtl/hwthr_pkg.sv
// Shared definitions for the half-wave tip heater regulator.
// Operation codes, register indexes, reset values and divide-by-ten constants.
// No dependencies.
package hwthr_pkg;

   localparam int TEMP_BITS_DEF    = 10;
   localparam int HISTORY_BITS_DEF = 32;
   localparam int PERIOD_BITS      = 8;
   localparam int POWER_HIST_BITS  = 32;

   localparam int TARGET_RESET     = 320;
   localparam int STANDBY_RESET    = 150;
   localparam int TEMP_LIMIT_RESET = 450;
   localparam int MAX_ON_RESET     = 4;

   localparam int HYSTERESIS       = 3;

   // x / 10 == (x * 0xCCCD) >> 19 holds exactly for every 16-bit x
   localparam int          DIV10_IN_BITS = 16;
   localparam int          DIV10_SHIFT   = 19;
   localparam int          DIV10_Q_BITS  = DIV10_IN_BITS - 3;
   localparam logic [15:0] DIV10_MUL     = 16'hCCCD;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [1:0] {
      OP_REGULATE = 2'd0,
      OP_TICK     = 2'd1,
      OP_HALT     = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_TEMP    = 2'd0,
      CSR_STANDBY_TEMP   = 2'd1,
      CSR_TEMP_LIMIT     = 2'd2,
      CSR_MAX_ON_PERIODS = 2'd3
   } csr_index_type;

endpackage

>>> rtl/hwthr_ifs.sv
// Channel interfaces of the half-wave tip heater regulator: request, response, csr write.
// Depends on hwthr_pkg.
interface hwthr_req_if #(
   parameter int TEMP_BITS = hwthr_pkg::TEMP_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           operation;
   logic [TEMP_BITS-1:0] tip_temp;
   logic                 standby;

   modport source (output valid, output operation, output tip_temp, output standby,
                   input ready);
   modport sink   (input valid, input operation, input tip_temp, input standby,
                   output ready);
endinterface

interface hwthr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   heater_on;
   logic                                   start_measure;
   logic [hwthr_pkg::PERIOD_BITS-1:0]      power_bar;
   logic [hwthr_pkg::POWER_HIST_BITS-1:0]  power_history;
   logic [hwthr_pkg::PERIOD_BITS-1:0]      periods_left;

   modport source (output valid, output heater_on, output start_measure, output power_bar,
                   output power_history, output periods_left, input ready);
   modport sink   (input valid, input heater_on, input start_measure, input power_bar,
                   input power_history, input periods_left, output ready);
endinterface

interface hwthr_csr_if #(
   parameter int TEMP_BITS = hwthr_pkg::TEMP_BITS_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic [hwthr_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [TEMP_BITS-1:0]                  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/half_wave_tip_heater_regulator.sv
// Half-wave tip heater regulator: a request beat passes the input register, then the state and
// response register that drives the response beat. Throughput one beat per cycle while the
// response channel does not stall; the divide by ten is a 16x16 reciprocal multiply inside
// the single compute stage. Synchronous reset empties both stages, clears the heater state and
// loads register defaults. Depends on hwthr_pkg and the channel interfaces in hwthr_ifs.
module half_wave_tip_heater_regulator #(
   parameter int TEMP_BITS    = hwthr_pkg::TEMP_BITS_DEF,
   parameter int HISTORY_BITS = hwthr_pkg::HISTORY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   hwthr_req_if.sink    req_ch,
   hwthr_rsp_if.source  rsp_ch,
   hwthr_csr_if.sink    csr_ch
);

   localparam int PB       = hwthr_pkg::PERIOD_BITS;
   localparam int PH       = hwthr_pkg::POWER_HIST_BITS;
   localparam int HIST_EXT = (HISTORY_BITS > PH) ? HISTORY_BITS : PH;
   localparam int QB       = hwthr_pkg::DIV10_Q_BITS;

   // configuration
   logic [TEMP_BITS-1:0] target_ff, standby_temp_ff, temp_limit_ff;
   logic [PB-1:0]        max_on_ff;

   // input stage
   logic                 s1_valid_ff;
   logic [1:0]           s1_op_ff;
   logic [TEMP_BITS-1:0] s1_tip_ff;
   logic                 s1_standby_ff;

   // regulator state, also the response payload
   logic [PB-1:0]           remaining_ff, remaining_in;
   logic [PB-1:0]           bar_ff, bar_in;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic                    heater_ff, heater_in;
   logic                    measure_ff, measure_in;
   logic                    rsp_valid_ff;

   logic                    advance;
   logic [TEMP_BITS-1:0]    goal;
   logic                    heat_needed;
   logic [TEMP_BITS-1:0]    diff;
   logic [31:0]             prod;
   logic [QB-1:0]           quot;
   logic [PB-1:0]           count;
   logic                    powered;
   logic [HIST_EXT-1:0]     hist_ext;

   // state only moves when the response slot is free, so it doubles as the output register
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff       <= TEMP_BITS'(hwthr_pkg::TARGET_RESET);
         standby_temp_ff <= TEMP_BITS'(hwthr_pkg::STANDBY_RESET);
         temp_limit_ff   <= TEMP_BITS'(hwthr_pkg::TEMP_LIMIT_RESET);
         max_on_ff       <= PB'(hwthr_pkg::MAX_ON_RESET);
      end else if (csr_ch.valid) begin
         case (hwthr_pkg::csr_index_type'(csr_ch.index))
            hwthr_pkg::CSR_TARGET_TEMP:    target_ff       <= csr_ch.data;
            hwthr_pkg::CSR_STANDBY_TEMP:   standby_temp_ff <= csr_ch.data;
            hwthr_pkg::CSR_TEMP_LIMIT:     temp_limit_ff   <= csr_ch.data;
            hwthr_pkg::CSR_MAX_ON_PERIODS: max_on_ff       <= csr_ch.data[PB-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_op_ff      <= req_ch.operation;
         s1_tip_ff     <= req_ch.tip_temp;
         s1_standby_ff <= req_ch.standby;
      end
   end

   // regulate: on-period count from the temperature deficit
   always_comb begin
      goal = target_ff;
      if (s1_standby_ff && (target_ff > standby_temp_ff)) begin
         goal = standby_temp_ff;
      end
      heat_needed = (({1'b0, s1_tip_ff} + (TEMP_BITS + 1)'(hwthr_pkg::HYSTERESIS))
                     < {1'b0, goal});
      diff = goal - s1_tip_ff;
      prod = 32'(hwthr_pkg::DIV10_IN_BITS'(diff)) * 32'(hwthr_pkg::DIV10_MUL);
      quot = QB'(prod >> hwthr_pkg::DIV10_SHIFT);
      if (quot > QB'(max_on_ff)) begin
         count = max_on_ff;
      end else if (quot == '0) begin
         count = PB'(1);
      end else begin
         count = quot[PB-1:0];
      end
   end

   assign powered = (remaining_ff != '0) && (s1_tip_ff < temp_limit_ff);

   always_comb begin
      remaining_in = remaining_ff;
      bar_in       = bar_ff;
      hist_in      = hist_ff;
      heater_in    = heater_ff;
      measure_in   = 1'b0;
      case (hwthr_pkg::op_type'(s1_op_ff))
         hwthr_pkg::OP_REGULATE: begin
            remaining_in = heat_needed ? count : '0;
         end
         hwthr_pkg::OP_TICK: begin
            bar_in    = remaining_ff;
            hist_in   = {hist_ff[HISTORY_BITS-2:0], powered};
            heater_in = powered;
            if (powered) begin
               remaining_in = remaining_ff - PB'(1);
            end else begin
               measure_in = 1'b1;
            end
         end
         hwthr_pkg::OP_HALT: begin
            remaining_in = '0;
            heater_in    = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         bar_ff       <= '0;
         hist_ff      <= '0;
         heater_ff    <= 1'b0;
         measure_ff   <= 1'b0;
      end else if (advance) begin
         remaining_ff <= remaining_in;
         bar_ff       <= bar_in;
         hist_ff      <= hist_in;
         heater_ff    <= heater_in;
         measure_ff   <= measure_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign hist_ext = HIST_EXT'(hist_ff);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.heater_on     = heater_ff;
   assign rsp_ch.start_measure = measure_ff;
   assign rsp_ch.power_bar     = bar_ff;
   assign rsp_ch.power_history = hist_ext[PH-1:0];
   assign rsp_ch.periods_left  = remaining_ff;

endmodule

>>> rtl/hwthr_checker.sv
// Port-level checks for the half-wave tip heater regulator, and the bind that attaches them.
// Depends on hwthr_pkg and half_wave_tip_heater_regulator.
module hwthr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  heater_on,
   input logic                                  start_measure,
   input logic [hwthr_pkg::PERIOD_BITS-1:0]     power_bar,
   input logic [hwthr_pkg::POWER_HIST_BITS-1:0] power_history,
   input logic [hwthr_pkg::PERIOD_BITS-1:0]     periods_left
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({heater_on, start_measure, power_bar, power_history, periods_left}))
      else $error("response beat changed while stalled");

   // a measurement request comes from an unpowered half-wave
   a_measure_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_measure |-> !heater_on && !power_history[0])
      else $error("measurement requested with heater powered");

   // an unpowered tick leaves the count as latched in the bar
   a_measure_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_measure |-> periods_left == power_bar)
      else $error("count moved on an unpowered half-wave");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

endmodule

bind half_wave_tip_heater_regulator hwthr_checker u_hwthr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .heater_on     (rsp_ch.heater_on),
   .start_measure (rsp_ch.start_measure),
   .power_bar     (rsp_ch.power_bar),
   .power_history (rsp_ch.power_history),
   .periods_left  (rsp_ch.periods_left)
);
